@@ hdl/iprd_pkg.sv @@
package iprd_pkg;

  localparam int MOD_WIDTH = 32;
  localparam int FIELD_W   = 32;
  localparam int DW        = MOD_WIDTH;
  localparam int CNT_W     = $clog2(MOD_WIDTH);
  localparam int LANES     = 4;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MOD_WIDTH - 1);

  localparam int LANE_ELEMENT = 0;
  localparam int LANE_WEIGHT  = 1;
  localparam int LANE_MESSAGE = 2;
  localparam int LANE_ACCUM   = 3;

  localparam logic [FIELD_W-1:0] MODULUS_RESET = FIELD_W'(2);
  localparam logic [DW-1:0]      MODULUS_MIN   = DW'(2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_PREP,
    ST_MULT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic reduce_step;
    logic prep;
    logic mul_step;
    logic finish;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic item_last;
  } status_t;

  function automatic logic [DW-1:0] fit_dp(input logic [FIELD_W-1:0] x);
    logic [DW+FIELD_W-1:0] t;
    t = {{DW{1'b0}}, x};
    return t[DW-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] fit_field(input logic [DW-1:0] x);
    logic [DW+FIELD_W-1:0] t;
    t = {{FIELD_W{1'b0}}, x};
    return t[FIELD_W-1:0];
  endfunction

  // Both operands are below q.
  function automatic logic [DW-1:0] add_mod(input logic [DW-1:0] a,
                                            input logic [DW-1:0] b,
                                            input logic [DW-1:0] q);
    logic [DW:0] s;
    logic [DW:0] qx;
    s  = {1'b0, a} + {1'b0, b};
    qx = {1'b0, q};
    if (s >= qx) begin
      return DW'(s - qx);
    end
    return DW'(s);
  endfunction

endpackage

@@ hdl/iprd_pair_if.sv @@
interface iprd_pair_if;
  logic                           valid;
  logic                           ready;
  logic [iprd_pkg::FIELD_W-1:0]   element;
  logic [iprd_pkg::FIELD_W-1:0]   weight;
  logic [iprd_pkg::FIELD_W-1:0]   message;
  logic                           last;

  modport source (output valid, element, weight, message, last, input ready);
  modport sink   (input valid, element, weight, message, last, output ready);
endinterface

@@ hdl/iprd_hash_if.sv @@
interface iprd_hash_if;
  logic                           valid;
  logic                           ready;
  logic                           hash_bit;
  logic [iprd_pkg::FIELD_W-1:0]   residue;

  modport source (output valid, hash_bit, residue, input ready);
  modport sink   (input valid, hash_bit, residue, output ready);
endinterface

@@ hdl/iprd_ctrl.sv @@
module iprd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output iprd_pkg::cmd_t    cmd,
  input  iprd_pkg::status_t status
);
  import iprd_pkg::*;

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic             cnt_last;

  assign cnt_last = (cnt == CNT_LAST);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_REDUCE;
      ST_REDUCE: if (cnt_last) state_next = ST_PREP;
      ST_PREP:   state_next = ST_MULT;
      ST_MULT:   if (cnt_last) state_next = ST_DONE;
      ST_DONE:   if (cmd.finish) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_ready     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_REDUCE: cmd.reduce_step = 1'b1;
      ST_PREP:   cmd.prep = 1'b1;
      ST_MULT:   cmd.mul_step = 1'b1;
      ST_DONE: begin
        cmd.finish   = !status.item_last || !out_valid || out_ready;
        cmd.out_load = cmd.finish && status.item_last;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load || cmd.prep) begin
        cnt <= '0;
      end else if (cmd.reduce_step || cmd.mul_step) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_REDUCE && cnt == '0)
    else $error("accepted item did not start the reduction");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE && $past(status.item_last))
    else $error("result raised outside the last pair's final step");

  a_mult_count_fresh: assert property (@(posedge clk) disable iff (rst)
    state == ST_PREP |=> state == ST_MULT && cnt == '0)
    else $error("multiply did not start from a cleared count");

endmodule

@@ hdl/iprd_dpath.sv @@
module iprd_dpath (
  input  logic                           clk,
  input  logic                           rst,
  input  iprd_pkg::cmd_t                 cmd,
  output iprd_pkg::status_t              status,
  input  logic [iprd_pkg::FIELD_W-1:0]   element,
  input  logic [iprd_pkg::FIELD_W-1:0]   weight,
  input  logic [iprd_pkg::FIELD_W-1:0]   message,
  input  logic                           last,
  input  logic                           modulus_we,
  input  logic [iprd_pkg::FIELD_W-1:0]   modulus_data,
  output logic                           hash_bit,
  output logic [iprd_pkg::FIELD_W-1:0]   residue
);
  import iprd_pkg::*;

  logic [FIELD_W-1:0] modulus;
  logic [DW-1:0]      q;
  logic [DW-1:0]      m_dp;
  logic [DW-1:0]      accumulator;
  logic               at_start;
  logic               item_last;

  logic [DW-1:0]      shf     [LANES];
  logic [DW-1:0]      rem     [LANES];
  logic [DW-1:0]      rem_next[LANES];

  logic [DW-1:0]      mul_a;
  logic [DW-1:0]      mul_b;
  logic [DW-1:0]      prod;
  logic [DW-1:0]      e_sub;
  logic [DW-1:0]      base;
  logic [DW-1:0]      sum;
  logic [DW-1:0]      half;

  assign m_dp = fit_dp(modulus);
  assign q    = (m_dp < MODULUS_MIN) ? MODULUS_MIN : m_dp;
  assign half = q >> 1;

  assign status.item_last = item_last;

  // One restoring step per lane: remainder doubles and takes the next bit.
  always_comb begin
    logic [DW:0] t;
    for (int i = 0; i < LANES; i++) begin
      t = {rem[i], shf[i][DW-1]};
      if (t >= {1'b0, q}) begin
        rem_next[i] = DW'(t - {1'b0, q});
      end else begin
        rem_next[i] = DW'(t);
      end
    end
  end

  always_comb begin
    e_sub = rem[LANE_ELEMENT] - rem[LANE_MESSAGE];
    if (rem[LANE_ELEMENT] < rem[LANE_MESSAGE]) begin
      e_sub = e_sub + q;
    end
    base = at_start ? '0 : rem[LANE_ACCUM];
    sum  = add_mod(base, prod, q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus     <= MODULUS_RESET;
      accumulator <= '0;
      at_start    <= 1'b1;
    end else begin
      if (modulus_we) begin
        modulus <= modulus_data;
      end
      if (cmd.finish) begin
        if (item_last) begin
          accumulator <= '0;
          at_start    <= 1'b1;
        end else begin
          accumulator <= sum;
          at_start    <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      shf[LANE_ELEMENT] <= fit_dp(element);
      shf[LANE_WEIGHT]  <= fit_dp(weight);
      shf[LANE_MESSAGE] <= fit_dp(message);
      shf[LANE_ACCUM]   <= accumulator;
      for (int i = 0; i < LANES; i++) begin
        rem[i] <= '0;
      end
      item_last <= last;
    end else if (cmd.reduce_step) begin
      for (int i = 0; i < LANES; i++) begin
        shf[i] <= shf[i] << 1;
        rem[i] <= rem_next[i];
      end
    end

    if (cmd.prep) begin
      mul_a <= at_start ? e_sub : rem[LANE_ELEMENT];
      mul_b <= rem[LANE_WEIGHT];
      prod  <= '0;
    end else if (cmd.mul_step) begin
      mul_a <= mul_a >> 1;
      mul_b <= add_mod(mul_b, mul_b, q);
      if (mul_a[0]) begin
        prod <= add_mod(prod, mul_b, q);
      end
    end

    if (cmd.out_load) begin
      residue  <= fit_field(sum);
      hash_bit <= (sum < half) ? sum[0] : ~sum[0];
    end
  end

endmodule

@@ hdl/mod_inner_product_round_unit.sv @@
// A result is loaded into the output register when its vector's last pair finishes.
// A new pair is taken only once the unit is idle again after the last one.
// The pace is set by the bit-per-cycle reduction of the operands modulo q and by
// the bit-per-cycle shift-and-add modular multiply, both in the datapath.
// A held result stalls only the next vector's last pair, in its final step.
// Synchronous reset sets the modulus to 2, clears the sum and starts a new vector.
module mod_inner_product_round_unit (
  input  logic                         clk,
  input  logic                         rst,
  iprd_pair_if.sink                    pairs,
  iprd_hash_if.source                  hashes,
  input  logic                         modulus_we,
  input  logic [iprd_pkg::FIELD_W-1:0] modulus_data
);
  import iprd_pkg::*;

  cmd_t    cmd;
  status_t status;

  iprd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pairs.valid),
    .in_ready  (pairs.ready),
    .out_valid (hashes.valid),
    .out_ready (hashes.ready),
    .cmd       (cmd),
    .status    (status)
  );

  iprd_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .element      (pairs.element),
    .weight       (pairs.weight),
    .message      (pairs.message),
    .last         (pairs.last),
    .modulus_we   (modulus_we),
    .modulus_data (modulus_data),
    .hash_bit     (hashes.hash_bit),
    .residue      (hashes.residue)
  );

endmodule
